>>> sv/hotp_pkg.sv
package hotp_pkg;

    localparam int KEY_BYTES   = 64;
    localparam int KIDX_W      = 6;
    localparam int KLEN_W      = 7;
    localparam int MAX_DIGITS  = 9;
    localparam logic [30:0] DEFAULT_STEP = 31'd30;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_DIGITS   = 3'd1;
    localparam logic [2:0] REG_STEP     = 3'd2;
    localparam logic [2:0] REG_BASELINE = 3'd3;
    localparam logic [2:0] REG_KEYLEN   = 3'd4;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5c;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_MOD,
        ST_OUT
    } state_t;

    // SHA-1 round function and constant
    function automatic logic [31:0] sha_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        if (t < 7'd20)      sha_f = (b & c) | (~b & d);
        else if (t < 7'd40) sha_f = b ^ c ^ d;
        else if (t < 7'd60) sha_f = (b & c) | (b & d) | (c & d);
        else                sha_f = b ^ c ^ d;
    endfunction

    function automatic logic [31:0] sha_k(input logic [6:0] t);
        if (t < 7'd20)      sha_k = 32'h5A827999;
        else if (t < 7'd40) sha_k = 32'h6ED9EBA1;
        else if (t < 7'd60) sha_k = 32'h8F1BBCDC;
        else                sha_k = 32'hCA62C1D6;
    endfunction

    function automatic logic [29:0] pow10(input logic [3:0] d);
        logic [29:0] r;
        r = 30'd1;
        unique case (d)
            4'd0: r = 30'd1;
            4'd1: r = 30'd10;
            4'd2: r = 30'd100;
            4'd3: r = 30'd1000;
            4'd4: r = 30'd10000;
            4'd5: r = 30'd100000;
            4'd6: r = 30'd1000000;
            4'd7: r = 30'd10000000;
            4'd8: r = 30'd100000000;
            default: r = 30'd1000000000;
        endcase
        return r;
    endfunction

endpackage

>>> sv/hotp_totp_code_generator_unit.sv
// A key word is stored with no result. A code word gives its result after the time
// less baseline is divided by the step (TOTP mode only), then an inner and an outer
// HMAC pass, each a key block and a message block through SHA-1, then a modulo; an
// empty key or a time before baseline goes straight to the result. Key blocks are
// built from one-byte key RAM reads. Throughput: one word at a time; a new word is
// taken once the result has left. Reset: aresetn sync, active low; key RAM kept.
module hotp_totp_code_generator_unit import hotp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // action, key_index, key_byte, moving_value, pad
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [31:0] m_tdata    // otp_code, code_valid, pad
);
    logic        mode_reg;
    logic [3:0]  digits_reg;
    logic [30:0] step_reg;
    logic [31:0] base_reg;
    logic [6:0]  klen_reg;

    logic [7:0]  key_mem [KEY_BYTES];
    logic [7:0]  key_rd_reg;

    state_t      st_reg, st_next;
    logic [63:0] cnt_reg;      // dividend / quotient
    logic [31:0] rem_reg;
    logic [6:0]  it_reg;       // generic iteration counter
    logic [1:0]  pass_reg;     // 0 inner key, 1 inner msg, 2 outer key, 3 outer msg
    logic [511:0] blk_reg;
    logic [159:0] h_reg, inner_reg;
    logic [29:0] code_reg;
    logic        cvalid_reg;
    logic [31:0] val_reg;
    logic [29:0] modv;
    logic        sha_start, sha_done;
    logic        sha_go_reg;
    logic [159:0] sha_out;
    logic [6:0]  klen_eff;
    logic [30:0] step_eff;
    logic [32:0] rem_try;
    logic [7:0]  kbyte;
    logic [3:0]  off;
    logic [159:0] mac;
    logic [31:0] val_w;

    hotp_sha1_core u_sha (
        .aclk(aclk), .aresetn(aresetn), .start(sha_start), .h_in(h_reg),
        .blk(blk_reg), .done(sha_done), .h_out(sha_out)
    );

    assign klen_eff = (klen_reg > 7'(KEY_BYTES)) ? 7'(KEY_BYTES) : klen_reg;
    assign step_eff = (step_reg == 31'd0) ? DEFAULT_STEP : step_reg;
    assign rem_try  = {rem_reg, cnt_reg[63]} - {2'b00, step_eff};
    assign modv     = pow10((digits_reg > 4'd9) ? 4'd9 : digits_reg);
    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = (st_reg == ST_OUT);
    assign m_tdata  = {1'b0, cvalid_reg, code_reg};

    // key byte seen by the block assembler: zero past key length
    assign kbyte = (it_reg > 7'd0 && (it_reg - 7'd1) < klen_eff) ? key_rd_reg : 8'h00;
    assign mac   = inner_reg;
    assign off   = mac[3:0];
    assign val_w = 32'(mac >> (8 * (16 - {28'd0, off}))) & 32'h7FFFFFFF;

    always_ff @(posedge aclk) begin
        if (cfg_we) begin
            unique case (cfg_index)
                REG_MODE:     mode_reg   <= cfg_wdata[0];
                REG_DIGITS:   digits_reg <= cfg_wdata[3:0];
                REG_STEP:     step_reg   <= cfg_wdata[30:0];
                REG_BASELINE: base_reg   <= cfg_wdata;
                REG_KEYLEN:   klen_reg   <= cfg_wdata[6:0];
                default: ;
            endcase
        end
        if (!aresetn) begin
            mode_reg   <= 1'b1;
            digits_reg <= 4'd6;
            step_reg   <= DEFAULT_STEP;
            base_reg   <= 32'd0;
            klen_reg   <= 7'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready && !s_tdata[0])
            key_mem[s_tdata[6:1]] <= s_tdata[14:7];
        key_rd_reg <= key_mem[it_reg[5:0]];
    end

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:  if (s_tvalid && s_tdata[0]) begin
                          if (klen_eff == 7'd0 || (mode_reg && s_tdata[78:15] < {32'd0, base_reg}))
                              st_next = ST_OUT;
                          else st_next = mode_reg ? ST_DIV : ST_LOAD;
                      end
            ST_DIV:   if (it_reg == 7'd63) st_next = ST_LOAD;
            ST_LOAD:  if (pass_reg[0] || it_reg == 7'd64) st_next = ST_ROUND;
            ST_ROUND: if (sha_done) st_next = ST_ADD;
            ST_ADD:   st_next = (pass_reg == 2'd3) ? ST_MOD : ST_LOAD;
            ST_MOD:   if (it_reg == 7'd32) st_next = ST_OUT;
            ST_OUT:   if (m_tready) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    // start in the first round cycle, once the block register holds the last byte
    assign sha_start = sha_go_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg     <= ST_IDLE;
            sha_go_reg <= 1'b0;
        end else begin
            st_reg     <= st_next;
            sha_go_reg <= (st_reg == ST_LOAD) && (st_next == ST_ROUND);
            unique case (st_reg)
                ST_IDLE: begin
                    it_reg     <= 7'd0;
                    pass_reg   <= 2'd0;
                    rem_reg    <= 32'd0;
                    h_reg      <= 160'h67452301EFCDAB8998BADCFE10325476C3D2E1F0;
                    code_reg   <= 30'd0;
                    cvalid_reg <= 1'b0;
                    cnt_reg    <= mode_reg ? (s_tdata[78:15] - {32'd0, base_reg})
                                           : s_tdata[78:15];
                end
                ST_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (!rem_try[32]) begin
                        rem_reg <= rem_try[31:0];
                        cnt_reg <= {cnt_reg[62:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[30:0], cnt_reg[63]};
                        cnt_reg <= {cnt_reg[62:0], 1'b0};
                    end
                    it_reg <= (it_reg == 7'd63) ? 7'd0 : it_reg + 7'd1;
                end
                ST_LOAD: begin
                    if (pass_reg == 2'd1)
                        blk_reg <= {cnt_reg, 8'h80, 376'd0, 64'd576};
                    else if (pass_reg == 2'd3)
                        blk_reg <= {inner_reg, 8'h80, 280'd0, 64'd672};
                    else begin
                        // one key byte per cycle; RAM read lags the index by one
                        if (it_reg != 7'd0)
                            blk_reg <= {blk_reg[503:0],
                                        kbyte ^ (pass_reg[1] ? OPAD : IPAD)};
                        it_reg <= (it_reg == 7'd64) ? 7'd0 : it_reg + 7'd1;
                    end
                end
                ST_ROUND: ;
                ST_ADD: begin
                    if (pass_reg == 2'd1) begin
                        inner_reg <= sha_out;
                        h_reg <= 160'h67452301EFCDAB8998BADCFE10325476C3D2E1F0;
                    end else begin
                        if (pass_reg == 2'd3) inner_reg <= sha_out;
                        h_reg <= sha_out;
                    end
                    pass_reg <= pass_reg + 2'd1;
                    it_reg   <= 7'd0;
                end
                ST_MOD: begin
                    // binary long remainder of the truncated value, a bit a cycle
                    if (it_reg == 7'd0) begin
                        val_reg <= val_w;
                        rem_reg <= 32'd0;
                    end else begin
                        if ({rem_reg[30:0], val_reg[31]} >= {2'd0, modv})
                            rem_reg <= {rem_reg[30:0], val_reg[31]} - {2'd0, modv};
                        else
                            rem_reg <= {rem_reg[30:0], val_reg[31]};
                        val_reg <= {val_reg[30:0], 1'b0};
                    end
                    it_reg <= it_reg + 7'd1;
                end
                ST_OUT: ;
                default: ;
            endcase
            if (st_reg == ST_MOD && st_next == ST_OUT) begin
                if ({rem_reg[30:0], val_reg[31]} >= {2'd0, modv})
                    code_reg <= 30'({rem_reg[30:0], val_reg[31]} - {2'd0, modv});
                else
                    code_reg <= 30'({rem_reg[30:0], val_reg[31]});
                cvalid_reg <= 1'b1;
            end
        end
    end
endmodule

>>> sv/hotp_sha1_core.sv
// One SHA-1 compression, one round per cycle; message schedule in a
// 16-word circular window.
module hotp_sha1_core import hotp_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [159:0]  h_in,
    input  logic [511:0]  blk,
    output logic          done,
    output logic [159:0]  h_out
);
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [511:0] w_reg;
    logic [6:0]   t_reg;
    logic         busy_reg, done_reg;
    logic [159:0] h_reg;
    logic [31:0]  wt, wn, tmp;

    assign wt  = w_reg[511:480];
    assign wn  = {w_reg[447:416] ^ w_reg[255:224] ^ w_reg[95:64] ^ w_reg[511:480]};
    assign tmp = {a_reg[26:0], a_reg[31:27]} + sha_f(t_reg, b_reg, c_reg, d_reg)
               + e_reg + sha_k(t_reg) + wt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                t_reg    <= 7'd0;
                w_reg    <= blk;
                h_reg    <= h_in;
                {a_reg, b_reg, c_reg, d_reg, e_reg} <= h_in;
            end else if (busy_reg) begin
                a_reg <= tmp;
                b_reg <= a_reg;
                c_reg <= {b_reg[1:0], b_reg[31:2]};
                d_reg <= c_reg;
                e_reg <= d_reg;
                w_reg <= {w_reg[479:0], wn[30:0], wn[31]};
                t_reg <= t_reg + 7'd1;
                if (t_reg == 7'd79) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign h_out = {h_reg[159:128] + a_reg, h_reg[127:96] + b_reg, h_reg[95:64] + c_reg,
                    h_reg[63:32] + d_reg, h_reg[31:0] + e_reg};
endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import hotp_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_MODE;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;   // action, key_index, key_byte, moving_value, pad
    logic        m_tready = 1'b0;
    logic        m_tvalid;
    logic [31:0] m_tdata;        // otp_code, code_valid, pad

    localparam logic ACT_KEY = 1'b0;
    localparam logic ACT_GEN = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [29:0] code;
    } otp_t;

    logic [79:0] word_q[$];
    otp_t        otp_q[$];
    bit          failed = 1'b0;
    bit          calm = 1'b0;
    int unsigned cycles = 0;

    // mirror of the block's settings and key store
    logic        m_mode = 1'b1;
    logic [3:0]  mir_digits = 4'd6;
    logic [30:0] m_step = DEFAULT_STEP;
    logic [31:0] m_base = '0;
    logic [6:0]  m_klen = '0;
    logic [7:0]  m_key[0:KEY_BYTES-1];

    hotp_totp_code_generator_unit u_top (.*);

    always #1 aclk = ~aclk;

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // SHA-1 of a short message (at most two blocks)
    function automatic logic [159:0] sha1_digest(input logic [7:0] msg[0:127], input int len);
        logic [7:0]  buf_b[0:127];
        logic [31:0] h[0:4];
        logic [31:0] w[0:79];
        logic [31:0] a, b, c, d, e, f, k, tmp;
        int nblk;
        for (int i = 0; i < 128; i++) buf_b[i] = (i < len) ? msg[i] : 8'h00;
        buf_b[len] = 8'h80;
        nblk = (len + 9 <= 64) ? 1 : 2;
        buf_b[nblk*64-2] = 8'((len * 8) >> 8);
        buf_b[nblk*64-1] = 8'(len * 8);
        h[0] = 32'h67452301; h[1] = 32'hEFCDAB89; h[2] = 32'h98BADCFE;
        h[3] = 32'h10325476; h[4] = 32'hC3D2E1F0;
        for (int blk = 0; blk < nblk; blk++) begin
            for (int t = 0; t < 16; t++)
                w[t] = {buf_b[blk*64+4*t], buf_b[blk*64+4*t+1],
                        buf_b[blk*64+4*t+2], buf_b[blk*64+4*t+3]};
            for (int t = 16; t < 80; t++)
                w[t] = rol(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
            a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
            for (int t = 0; t < 80; t++) begin
                if (t < 20) begin
                    f = (b & c) | (~b & d); k = 32'h5A827999;
                end else if (t < 40) begin
                    f = b ^ c ^ d; k = 32'h6ED9EBA1;
                end else if (t < 60) begin
                    f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
                end else begin
                    f = b ^ c ^ d; k = 32'hCA62C1D6;
                end
                tmp = rol(a, 5) + f + e + k + w[t];
                e = d; d = c; c = rol(b, 30); b = a; a = tmp;
            end
            h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
        end
        return {h[0], h[1], h[2], h[3], h[4]};
    endfunction

    function automatic otp_t otp_code_for(input logic [63:0] mv);
        logic [7:0]   ibuf[0:127];
        logic [7:0]   obuf[0:127];
        logic [159:0] dg;
        logic [7:0]   mac[0:19];
        logic [63:0]  ctr, modv, step;
        logic [31:0]  val;
        logic [7:0]  kb;
        int klen, nd, off;
        otp_t r;
        r = '0;
        klen = (m_klen > KEY_BYTES) ? KEY_BYTES : int'(m_klen);
        if (klen == 0) return r;
        ctr = mv;
        if (m_mode) begin
            step = (m_step == '0) ? 64'd30 : 64'(m_step);
            if (mv < 64'(m_base)) return r;
            ctr = (mv - 64'(m_base)) / step;
        end
        for (int i = 0; i < 128; i++) begin
            ibuf[i] = 8'h00; obuf[i] = 8'h00;
        end
        for (int i = 0; i < 64; i++) begin
            kb = (i < klen) ? m_key[i] : 8'h00;
            ibuf[i] = kb ^ IPAD;
            obuf[i] = kb ^ OPAD;
        end
        for (int i = 0; i < 8; i++) ibuf[64+i] = ctr[63-8*i -: 8];
        dg = sha1_digest(ibuf, 72);
        for (int i = 0; i < 20; i++) obuf[64+i] = dg[159-8*i -: 8];
        dg = sha1_digest(obuf, 84);
        for (int i = 0; i < 20; i++) mac[i] = dg[159-8*i -: 8];
        off = mac[19][3:0];
        val = {1'b0, mac[off][6:0], mac[off+1], mac[off+2], mac[off+3]};
        nd = (mir_digits > MAX_DIGITS) ? MAX_DIGITS : int'(mir_digits);
        modv = 64'd1;
        for (int i = 0; i < nd; i++) modv *= 64'd10;
        r.code = 30'(64'(val) % modv);
        r.valid = 1'b1;
        return r;
    endfunction

    function automatic logic [79:0] key_word(input logic [5:0] idx, input logic [7:0] kb);
        return {1'b0, 64'($urandom), kb, idx, ACT_KEY};
    endfunction

    function automatic logic [79:0] gen_word(input logic [63:0] mv);
        return {1'b0, mv, 8'($urandom), 6'($urandom), ACT_GEN};
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                if (s_tdata[0] == ACT_GEN) otp_q.push_back(otp_code_for(s_tdata[78:15]));
                else m_key[s_tdata[6:1]] = s_tdata[14:7];
            end
            if (word_q.size() > 0 && (calm || $urandom_range(99) >= 11)) begin
                s_tvalid <= 1'b1;
                s_tdata <= word_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        otp_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (otp_q.size() == 0) begin
                    $error("unexpected result word %h", m_tdata);
                    failed = 1'b1;
                end else begin
                    want = otp_q.pop_front();
                    if (m_tdata[29:0] !== want.code) begin
                        $error("otp_code exp %0d got %0d", want.code, m_tdata[29:0]);
                        failed = 1'b1;
                    end
                    if (m_tdata[30] !== want.valid) begin
                        $error("code_valid exp %0d got %0d", want.valid, m_tdata[30]);
                        failed = 1'b1;
                    end
                end
            end
            m_tready <= calm || $urandom_range(99) >= 11;
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic drain();
        while (word_q.size() > 0 || s_tvalid || otp_q.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [31:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        case (idx)
            REG_MODE:     m_mode = v[0];
            REG_DIGITS:   mir_digits = v[3:0];
            REG_STEP:     m_step = v[30:0];
            REG_BASELINE: m_base = v;
            default:      m_klen = v[6:0];
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand_time();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0 && m_base != 0) return 64'(m_base) - 64'($urandom_range(1, 1000));
        if (sel == 1) return {$urandom, $urandom};
        if (sel == 2) return 64'(m_base);
        return 64'(m_base) + (sel < 6 ? 64'($urandom_range(0, 5000)) : 64'($urandom));
    endfunction

    initial begin
        int sent;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // empty key after reset
        word_q.push_back(gen_word(64'd59));
        drain();
        // fill whole key store: ascii digits first, then edge bytes, then random bytes
        for (int i = 0; i < KEY_BYTES; i++)
            word_q.push_back(key_word(6'(i), i < 20 ? 8'h30 + 8'((i + 1) % 10) :
                                      (i == 20 ? 8'hFF : (i == 21 ? 8'h00 : 8'($urandom)))));
        drain();
        set_reg(REG_KEYLEN, 32'd20);
        set_reg(REG_MODE, 32'd0);
        word_q.push_back(gen_word(64'd0));
        word_q.push_back(gen_word(64'd1));
        word_q.push_back(gen_word('1));
        drain();
        set_reg(REG_MODE, 32'd1);
        set_reg(REG_DIGITS, 32'd9);
        set_reg(REG_STEP, 32'd0);
        word_q.push_back(gen_word(64'd59));
        word_q.push_back(gen_word(64'd1111111109));
        word_q.push_back(gen_word('1));
        drain();
        set_reg(REG_DIGITS, 32'd0);
        set_reg(REG_STEP, 32'hFFFF_FFFF);
        set_reg(REG_BASELINE, 32'hFFFF_FFFF);
        set_reg(REG_KEYLEN, 32'd64);
        word_q.push_back(gen_word(64'hFFFF_FFFE));
        word_q.push_back(gen_word('1));
        drain();
        set_reg(REG_DIGITS, 32'd15);
        set_reg(REG_STEP, 32'd1);
        set_reg(REG_BASELINE, 32'd0);
        set_reg(REG_KEYLEN, 32'd127);
        word_q.push_back(gen_word(64'd0));
        word_q.push_back(gen_word({$urandom, $urandom}));
        drain();

        sent = 0;
        for (int ph = 0; sent < 1400; ph++) begin
            calm = (ph % 8) == 5;
            set_reg(REG_MODE, 32'($urandom_range(1)));
            set_reg(REG_DIGITS, $urandom_range(3) == 0 ? $urandom : 32'($urandom_range(4, 9)));
            case ($urandom_range(4))
                0: set_reg(REG_STEP, 32'd0);
                1: set_reg(REG_STEP, 32'h7FFF_FFFF);
                2: set_reg(REG_STEP, 32'($urandom_range(1, 120)));
                default: set_reg(REG_STEP, $urandom);
            endcase
            case ($urandom_range(3))
                0: set_reg(REG_BASELINE, 32'd0);
                1: set_reg(REG_BASELINE, 32'hFFFF_FFFF);
                default: set_reg(REG_BASELINE, $urandom);
            endcase
            case ($urandom_range(5))
                0: set_reg(REG_KEYLEN, 32'd0);
                1: set_reg(REG_KEYLEN, 32'd64);
                2: set_reg(REG_KEYLEN, 32'($urandom_range(65, 127)));
                default: set_reg(REG_KEYLEN, 32'($urandom_range(1, 64)));
            endcase
            for (int n = 0; n < 40; n++) begin
                if ($urandom_range(3) == 0) word_q.push_back(gen_word(rand_time()));
                else word_q.push_back(key_word(6'($urandom), 8'($urandom)));
                sent++;
            end
            drain();
        end
        calm = 1'b0;
        repeat (50) @(posedge aclk);
        if (!failed) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
sv/hotp_pkg.sv
sv/hotp_sha1_core.sv
sv/hotp_totp_code_generator_unit.sv
sim/tb_top.sv
